>>> rtl/blr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

  // Field widths of the command and pixel words.
  localparam int CoordW = 12;
  localparam int ColorW = 8;
  localparam int PixW   = 6;

  // A command never produces more than this many pixels.
  localparam int MaxResults = 64;
  localparam int CntW       = 6;

  // The error term stays within (-2*major, 2*major), so 14 signed bits suffice.
  localparam int ErrW = 14;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_END,
    ST_WALK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit_end;
    logic step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_ok;
    logic major_zero;
    logic walk_last;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/blr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module blr_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  blr_pkg::dp_status_t  status,
  output blr_pkg::ctrl_cmd_t   cmd,
  output logic                 busy
);

  import blr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.emit_end = 1'b0;
    cmd.step     = 1'b0;
    busy         = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        // A command with a coordinate off the display is taken and dropped.
        if (start && status.in_ok) begin
          cmd.load  = 1'b1;
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        cmd.emit_end = 1'b1;
        if (status.major_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (status.walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/blr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module blr_datapath #(
  parameter int DISPLAY_WIDTH  = 64,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [blr_pkg::CoordW-1:0]     in_x_start,
  input  wire  [blr_pkg::CoordW-1:0]     in_y_start,
  input  wire  [blr_pkg::CoordW-1:0]     in_x_end,
  input  wire  [blr_pkg::CoordW-1:0]     in_y_end,
  input  wire  [blr_pkg::ColorW-1:0]     in_color,
  input  blr_pkg::ctrl_cmd_t             cmd,
  output blr_pkg::dp_status_t            status,
  output logic                           out_valid,
  output logic [blr_pkg::PixW-1:0]       out_pixel_x,
  output logic [blr_pkg::PixW-1:0]       out_pixel_y,
  output logic [blr_pkg::ColorW-1:0]     out_pixel_color,
  output logic                           out_last_pixel
);

  import blr_pkg::*;

  localparam logic [CoordW-1:0] WidthLim  = CoordW'(DISPLAY_WIDTH);
  localparam logic [CoordW-1:0] HeightLim = CoordW'(DISPLAY_HEIGHT);
  localparam logic [CntW-1:0]   WalkCap   = CntW'(MaxResults - 2);

  // Walk state.
  logic [CoordW-1:0]      x_r, y_r, xe_r, ye_r;
  logic                   ux_r, uy_r, xmaj_r;
  logic [CoordW-1:0]      dmaj_r, dmin_r, rem_r;
  logic signed [ErrW-1:0] err_r;
  logic [CntW-1:0]        k_r;
  logic [ColorW-1:0]      color_r;

  // Output word register.
  logic                   valid_r;
  logic [PixW-1:0]        px_r, py_r;
  logic [ColorW-1:0]      pcol_r;
  logic                   last_r;

  // Deltas of the incoming command.
  logic signed [CoordW:0] dx_s, dy_s;
  logic [CoordW-1:0]      adx, ady;

  // Error update of one walk step.
  logic signed [ErrW-1:0] err_sum;
  logic signed [ErrW:0]   err_dbl;
  logic                   minor_step;
  logic signed [ErrW-1:0] err_nxt;
  logic [CoordW-1:0]      x_inc, y_inc, x_nxt, y_nxt;

  // Deltas on the input ports.
  always_comb begin
    dx_s = $signed({1'b0, in_x_end}) - $signed({1'b0, in_x_start});
    dy_s = $signed({1'b0, in_y_end}) - $signed({1'b0, in_y_start});
    adx  = dx_s[CoordW] ? CoordW'(-dx_s) : CoordW'(dx_s);
    ady  = dy_s[CoordW] ? CoordW'(-dy_s) : CoordW'(dy_s);
  end

  // One Bresenham step: add the minor delta, step minor when 2*err >= major.
  always_comb begin
    err_sum    = err_r + $signed({2'b00, dmin_r});
    err_dbl    = {err_sum, 1'b0};
    minor_step = err_dbl >= $signed({3'b000, dmaj_r});
    err_nxt    = minor_step ? (err_sum - $signed({2'b00, dmaj_r})) : err_sum;
    x_inc      = ux_r ? (x_r + CoordW'(1)) : (x_r - CoordW'(1));
    y_inc      = uy_r ? (y_r + CoordW'(1)) : (y_r - CoordW'(1));
    if (xmaj_r) begin
      x_nxt = x_inc;
      y_nxt = minor_step ? y_inc : y_r;
    end else begin
      y_nxt = y_inc;
      x_nxt = minor_step ? x_inc : x_r;
    end
  end

  // Status for the controller: range check on the input ports and walk progress.
  always_comb begin
    status.in_ok      = (in_x_start < WidthLim) && (in_x_end < WidthLim) &&
                        (in_y_start < HeightLim) && (in_y_end < HeightLim);
    status.major_zero = (dmaj_r == '0);
    status.walk_last  = (rem_r == CoordW'(1)) || (k_r == WalkCap);
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_x_start;
      y_r     <= in_y_start;
      xe_r    <= in_x_end;
      ye_r    <= in_y_end;
      color_r <= in_color;
      ux_r    <= !dx_s[CoordW] && (dx_s != '0);
      uy_r    <= !dy_s[CoordW] && (dy_s != '0);
      xmaj_r  <= adx > ady;
      dmaj_r  <= (adx > ady) ? adx : ady;
      dmin_r  <= (adx > ady) ? ady : adx;
      rem_r   <= (adx > ady) ? adx : ady;
      err_r   <= '0;
      k_r     <= '0;
    end else if (cmd.step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
      rem_r <= rem_r - CoordW'(1);
      k_r   <= k_r + CntW'(1);
    end
  end

  // Output word: the end pixel first, then one walk pixel per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit_end || cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_end) begin
      px_r   <= xe_r[PixW-1:0];
      py_r   <= ye_r[PixW-1:0];
      pcol_r <= color_r;
      last_r <= status.major_zero;
    end else if (cmd.step) begin
      px_r   <= x_r[PixW-1:0];
      py_r   <= y_r[PixW-1:0];
      pcol_r <= color_r;
      last_r <= status.walk_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = pcol_r;
  assign out_last_pixel  = last_r;

endmodule

`default_nettype wire

>>> rtl/bresenham_line_rasterizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A taken command is loaded, ST_END emits its end pixel, and the output word register shows it.
// One pixel per cycle; busy stays high through ST_END and the walk steps of a command,
// which yields at most 64 pixels; the rate is set by the single step unit of the error walk.
// A command with an off-display coordinate is dropped and busy stays low.
// Reset is synchronous and active low; it idles the controller and clears the strobe.
// Pixels are strobed for one cycle each and the receiver cannot stall them.

module bresenham_line_rasterizer_unit #(
  parameter int DISPLAY_WIDTH  = 64,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [blr_pkg::CoordW-1:0]   in_x_start,
  input  wire  [blr_pkg::CoordW-1:0]   in_y_start,
  input  wire  [blr_pkg::CoordW-1:0]   in_x_end,
  input  wire  [blr_pkg::CoordW-1:0]   in_y_end,
  input  wire  [blr_pkg::ColorW-1:0]   in_color,
  output logic                         out_valid,
  output logic [blr_pkg::PixW-1:0]     out_pixel_x,
  output logic [blr_pkg::PixW-1:0]     out_pixel_y,
  output logic [blr_pkg::ColorW-1:0]   out_pixel_color,
  output logic                         out_last_pixel
);

  import blr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  blr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Error walk and output word.
  blr_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_color        (in_color),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

  // Every pixel word comes from a cycle in which a line was in progress.
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("pixel strobe without a line in progress");

  // When a line finishes, the word on the outputs is its last pixel.
  a_end_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && $past(busy) && $past(rst_n)) |-> (out_valid && out_last_pixel))
    else $error("line ended without a last pixel");

  // A newly taken command has no pixel ready in the following cycle.
  a_no_pixel_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("pixel strobe right after command accept");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import blr_pkg::*;

  localparam int DispW     = 64;
  localparam int DispH     = 64;
  localparam int PerPhase  = 62;
  localparam int MaxReport = 10;

  // How a directed line is checked: by the line walker, by a result typed in, or as a dropped command.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_DROP,
    CHK_DOT
  } line_chk_t;

  typedef struct packed {
    logic [CoordW-1:0] xs;
    logic [CoordW-1:0] ys;
    logic [CoordW-1:0] xe;
    logic [CoordW-1:0] ye;
    logic [ColorW-1:0] color;
    line_chk_t         chk;
  } line_cmd_t;

  typedef struct packed {
    logic [PixW-1:0]   px;
    logic [PixW-1:0]   py;
    logic [ColorW-1:0] pcolor;
    logic              last;
  } pixel_t;

  localparam int NumDir = 24;

  // Directed lines: points, full diagonals, axis lines both ways, shallow and
  // steep slopes, and commands with a coordinate off the display.
  line_cmd_t dir_tbl [NumDir] = '{
    '{12'd0,    12'd0,    12'd0,    12'd0,    8'h00, CHK_DOT},
    '{12'd63,   12'd63,   12'd63,   12'd63,   8'hFF, CHK_DOT},
    '{12'd21,   12'd42,   12'd21,   12'd42,   8'hAA, CHK_DOT},
    '{12'd0,    12'd0,    12'd63,   12'd63,   8'h55, CHK_MODEL},
    '{12'd63,   12'd63,   12'd0,    12'd0,    8'hAA, CHK_MODEL},
    '{12'd63,   12'd0,    12'd0,    12'd63,   8'h0F, CHK_MODEL},
    '{12'd0,    12'd0,    12'd63,   12'd0,    8'hF0, CHK_MODEL},
    '{12'd63,   12'd5,    12'd0,    12'd5,    8'h01, CHK_MODEL},
    '{12'd7,    12'd0,    12'd7,    12'd63,   8'h80, CHK_MODEL},
    '{12'd7,    12'd63,   12'd7,    12'd0,    8'h7F, CHK_MODEL},
    '{12'd0,    12'd0,    12'd63,   12'd1,    8'h33, CHK_MODEL},
    '{12'd0,    12'd0,    12'd1,    12'd63,   8'hCC, CHK_MODEL},
    '{12'd60,   12'd2,    12'd3,    12'd40,   8'h12, CHK_MODEL},
    '{12'd10,   12'd50,   12'd12,   12'd3,    8'h34, CHK_MODEL},
    '{12'd5,    12'd5,    12'd6,    12'd5,    8'h56, CHK_MODEL},
    '{12'd5,    12'd5,    12'd4,    12'd6,    8'h78, CHK_MODEL},
    '{12'd64,   12'd0,    12'd0,    12'd0,    8'h11, CHK_DROP},
    '{12'd0,    12'd64,   12'd0,    12'd0,    8'h22, CHK_DROP},
    '{12'd0,    12'd0,    12'd64,   12'd0,    8'h44, CHK_DROP},
    '{12'd0,    12'd0,    12'd0,    12'd64,   8'h88, CHK_DROP},
    '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'hFF, CHK_DROP},
    '{12'd2048, 12'd1,    12'd1,    12'd1,    8'h00, CHK_DROP},
    '{12'd1,    12'd1,    12'd1,    12'd3000, 8'h9C, CHK_DROP},
    '{12'd31,   12'd17,   12'd45,   12'd61,   8'hE7, CHK_MODEL}
  };

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CoordW-1:0] in_x_start = '0;
  logic [CoordW-1:0] in_y_start = '0;
  logic [CoordW-1:0] in_x_end = '0;
  logic [CoordW-1:0] in_y_end = '0;
  logic [ColorW-1:0] in_color = '0;
  line_chk_t         cur_chk = CHK_MODEL;
  logic              out_valid;
  logic [PixW-1:0]   out_pixel_x;
  logic [PixW-1:0]   out_pixel_y;
  logic [ColorW-1:0] out_pixel_color;
  logic              out_last_pixel;

  pixel_t expected_q [$];
  int     mismatch_cnt = 0;
  int     line_cnt = 0;
  int     drop_cnt = 0;
  int     pixel_cnt = 0;

  bresenham_line_rasterizer_unit #(
    .DISPLAY_WIDTH (DispW),
    .DISPLAY_HEIGHT(DispH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_color       (in_color),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_last_pixel (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void log_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReport) $display("%0t: %s", $time, msg);
  endfunction

  // Queue one expected pixel unless the line already holds the most a command may emit.
  function automatic int push_pixel(input int x, input int y, input logic [ColorW-1:0] col,
                                    input int n);
    pixel_t pix;
    if (n >= MaxResults) return n;
    pix.px     = x[PixW-1:0];
    pix.py     = y[PixW-1:0];
    pix.pcolor = col;
    pix.last   = 1'b0;
    expected_q.push_back(pix);
    return n + 1;
  endfunction

  // Line walker: end pixel first, then the error walk from the start, end excluded.
  function automatic void walk_line(input line_cmd_t c);
    int xs, ys, xe, ye, dx, dy, sx, sy, err, n;
    if (c.xs >= DispW || c.ys >= DispH || c.xe >= DispW || c.ye >= DispH) begin
      drop_cnt++;
      return;
    end
    xs = int'(c.xs);
    ys = int'(c.ys);
    xe = int'(c.xe);
    ye = int'(c.ye);
    dx = xe - xs;
    dy = ye - ys;
    sx = (dx > 0) ? 1 : -1;
    sy = (dy > 0) ? 1 : -1;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    err = 0;
    n = push_pixel(xe, ye, c.color, 0);
    if (dx > dy) begin
      while (xs != xe && n < MaxResults) begin
        n = push_pixel(xs, ys, c.color, n);
        err += dy;
        if (2 * err >= dx) begin
          ys += sy;
          err -= dx;
        end
        xs += sx;
      end
    end else begin
      while (ys != ye && n < MaxResults) begin
        n = push_pixel(xs, ys, c.color, n);
        err += dx;
        if (2 * err >= dy) begin
          xs += sx;
          err -= dy;
        end
        ys += sy;
      end
    end
    expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  // Pixel checker and command capture, both sampled at the rising edge.
  always @(posedge clk) begin : mon
    pixel_t    got;
    pixel_t    want;
    line_cmd_t c;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel};
        pixel_cnt++;
        if (expected_q.size() == 0) begin
          log_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%02h last=%0b",
                                 got.px, got.py, got.pcolor, got.last));
        end else begin
          want = expected_q.pop_front();
          if (got.px != want.px || got.py != want.py || got.pcolor != want.pcolor ||
              got.last != want.last) begin
            log_mismatch($sformatf({"pixel mismatch: expected x=%0d y=%0d color=%02h ",
                                    "last=%0b, got x=%0d y=%0d color=%02h last=%0b"},
                                   want.px, want.py, want.pcolor, want.last,
                                   got.px, got.py, got.pcolor, got.last));
          end
        end
      end
      if (start && !busy) begin
        c = '{in_x_start, in_y_start, in_x_end, in_y_end, in_color, cur_chk};
        line_cnt++;
        case (cur_chk)
          CHK_DROP: drop_cnt++;
          CHK_DOT:  expected_q.push_back('{c.xe[PixW-1:0], c.ye[PixW-1:0], c.color, 1'b1});
          default:  walk_line(c);
        endcase
      end
    end
  end

  // Present one command and hold it until the block takes it.
  task automatic issue_line(input line_cmd_t c);
    in_x_start <= c.xs;
    in_y_start <= c.ys;
    in_x_end   <= c.xe;
    in_y_end   <= c.ye;
    in_color   <= c.color;
    cur_chk    <= c.chk;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mostly on-display lines, a fair share short; the rest push a coordinate off the edge.
  function automatic line_cmd_t rand_line();
    line_cmd_t c;
    int        pick;
    c.xs    = CoordW'($urandom_range(0, DispW - 1));
    c.ys    = CoordW'($urandom_range(0, DispH - 1));
    c.color = ColorW'($urandom_range(0, 255));
    c.chk   = CHK_MODEL;
    if ($urandom_range(0, 99) < 30) begin
      c.xe = CoordW'((c.xs + $urandom_range(0, 6)) % DispW);
      c.ye = CoordW'((c.ys + DispH - $urandom_range(0, 6)) % DispH);
    end else begin
      c.xe = CoordW'($urandom_range(0, DispW - 1));
      c.ye = CoordW'($urandom_range(0, DispH - 1));
    end
    if ($urandom_range(0, 99) < 20) begin
      pick = int'($urandom_range(0, 4));
      case (pick)
        0: c.xs = CoordW'($urandom_range(DispW, 4095));
        1: c.ys = CoordW'($urandom_range(DispH, 4095));
        2: c.xe = CoordW'($urandom_range(DispW, 4095));
        3: c.ye = CoordW'($urandom_range(DispH, 4095));
        default: begin
          c.xs = CoordW'($urandom_range(0, 4095));
          c.ys = CoordW'($urandom_range(DispH, 4095));
          c.xe = CoordW'($urandom_range(0, 4095));
          c.ye = CoordW'($urandom_range(0, 4095));
        end
      endcase
    end
    return c;
  endfunction

  initial begin : stim
    int idle_pct [3];
    idle_pct = '{0, 76, 13};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines, back to back.
    for (int i = 0; i < NumDir; i++) issue_line(dir_tbl[i]);

    // Random lines in three phases: no sender gaps, mostly idle, lightly idle.
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < PerPhase; i++) begin
        issue_line(rand_line());
        while ($urandom_range(0, 99) < idle_pct[ph]) begin
          start <= 1'b0;
          @(posedge clk);
        end
      end
    end
    start <= 1'b0;

    // Drain outstanding pixels, then keep watching for stray ones.
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d line commands (%0d dropped off-display), checked %0d pixels.",
             line_cnt, drop_cnt, pixel_cnt);
    $display("Mismatches: %0d.", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
